// File: rtl/rgm_pkg.sv
// Shared types, widths and constants of the replay gain multiplier.
// No dependencies; every other file of the block imports this package.
package rgm_pkg;

    localparam int GAIN_W     = 16;
    localparam int PEAK_W     = 20;
    localparam int OG_W       = 20;
    localparam int MULT_W     = 24;
    localparam int SUM_W      = 18;
    localparam int EXP_W      = 41;
    localparam int N_W        = 9;
    localparam int F_W        = 32;
    localparam int Y_W        = 30;
    localparam int TERM_W     = 31;
    localparam int R_W        = 32;
    localparam int M_W        = 32;
    localparam int PK_W       = 19;
    localparam int LIM_W      = 33;
    localparam int SERIES_K   = 12;
    localparam int DIV_STAGES = 28;
    localparam int DIV_SPS    = 2;
    localparam int DIV_W      = DIV_STAGES * DIV_SPS;
    localparam int FIX_W      = TERM_W + 4;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 20;

    localparam logic [22:0]             LOG2_10_OVER_20_Q24 = 23'd2786635;
    localparam logic [Y_W-1:0]          LN2_Q30             = 30'd744261118;
    localparam logic signed [SUM_W-1:0] REF_LUFS_Q8         = -18'sd4608;
    localparam logic [PK_W-1:0]         ONE_Q16             = 19'd65536;
    localparam logic [TERM_W-1:0]       ONE_Q30             = 31'h4000_0000;
    localparam logic [MULT_W-1:0]       MULT_MAX            = 24'hFF_FFFF;

    localparam logic [1:0] MODE_TRACK = 2'd0;
    localparam logic [1:0] MODE_ALBUM = 2'd1;
    localparam logic [1:0] MODE_OFF   = 2'd2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GAIN_MODE    = 3'd0,
        CFG_PREAMP_DB    = 3'd1,
        CFG_FALLBACK_DB  = 3'd2,
        CFG_PEAK_PROTECT = 3'd3,
        CFG_OUTPUT_GAIN  = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic [1:0]               gain_mode;
        logic signed [GAIN_W-1:0] preamp_db;
        logic signed [GAIN_W-1:0] fallback_gain_db;
        logic                     peak_protect_enable;
        logic [OG_W-1:0]          output_gain;
    } t_cfg;

    // Per-item control that travels with the data down the pipeline.
    typedef struct packed {
        logic off;
        logic cap;
    } t_meta;

    // Turns q0 (floor(x/k) or one less) into the exact floor(x/k).
    function automatic logic [TERM_W-1:0] div_fix(logic [TERM_W-1:0] q,
                                                  logic [TERM_W-1:0] x,
                                                  logic [3:0] k);
        logic [FIX_W-1:0] rem;
        rem = FIX_W'(x) - FIX_W'(q) * FIX_W'(k);
        return (rem >= FIX_W'(k)) ? q + 1'b1 : q;
    endfunction

endpackage

// File: rtl/rgm_front.sv
// Front stages: tag selection and dB sum, base-2 exponent split, ln2 scaling.
// Depends on rgm_pkg.
module rgm_front import rgm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_en,
    input  logic                     i_valid,
    input  t_cfg                     i_cfg,
    input  logic                     i_track_gain_present,
    input  logic signed [GAIN_W-1:0] i_track_gain_db,
    input  logic                     i_album_gain_present,
    input  logic signed [GAIN_W-1:0] i_album_gain_db,
    input  logic                     i_track_peak_present,
    input  logic signed [PEAK_W-1:0] i_track_peak,
    input  logic                     i_album_peak_present,
    input  logic signed [PEAK_W-1:0] i_album_peak,
    input  logic                     i_ref_loudness_present,
    input  logic signed [GAIN_W-1:0] i_ref_loudness_lufs,
    output logic [PK_W-1:0]          o_pk,
    output logic                     o_valid,
    output t_meta                    o_meta,
    output logic signed [N_W-1:0]    o_n,
    output logic [Y_W-1:0]           o_y
);

    logic                     sel;
    logic                     have;
    logic signed [GAIN_W-1:0] g;
    logic                     hp;
    logic signed [PEAK_W-1:0] pk_raw;
    logic signed [SUM_W-1:0]  ref_term;
    logic signed [SUM_W-1:0]  n_s;
    logic [PK_W-1:0]          n_pk;
    t_meta                    n_meta;
    logic [EXP_W-1:0]         p;
    logic [F_W+Y_W-1:0]       prod_y;

    logic                     r1_valid, r2_valid, r3_valid;
    logic signed [SUM_W-1:0]  r1_s;
    logic [PK_W-1:0]          r1_pk;
    t_meta                    r1_meta, r2_meta, r3_meta;
    logic signed [N_W-1:0]    r2_n, r3_n;
    logic [F_W-1:0]           r2_f;
    logic [Y_W-1:0]           r3_y;

    // The selected gain falls back to the other one when it is missing.
    always_comb begin
        if (!(i_cfg.gain_mode[0] ? i_album_gain_present : i_track_gain_present) &&
            (i_cfg.gain_mode[0] ? i_track_gain_present : i_album_gain_present)) begin
            sel = !i_cfg.gain_mode[0];
        end else begin
            sel = i_cfg.gain_mode[0];
        end
        have   = sel ? i_album_gain_present : i_track_gain_present;
        g      = sel ? i_album_gain_db : i_track_gain_db;
        hp     = sel ? i_album_peak_present : i_track_peak_present;
        pk_raw = sel ? i_album_peak : i_track_peak;
        if (i_ref_loudness_present) begin
            ref_term = REF_LUFS_Q8 -
                       {{(SUM_W-GAIN_W){i_ref_loudness_lufs[GAIN_W-1]}}, i_ref_loudness_lufs};
        end else begin
            ref_term = '0;
        end
        if (have) begin
            n_s = {{(SUM_W-GAIN_W){g[GAIN_W-1]}}, g} +
                  {{(SUM_W-GAIN_W){i_cfg.preamp_db[GAIN_W-1]}}, i_cfg.preamp_db} + ref_term;
        end else begin
            n_s = {{(SUM_W-GAIN_W){i_cfg.fallback_gain_db[GAIN_W-1]}},
                   i_cfg.fallback_gain_db};
        end
        if (hp && !pk_raw[PEAK_W-1] && (pk_raw != '0)) begin
            n_pk = pk_raw[PK_W-1:0];
        end else begin
            n_pk = ONE_Q16;
        end
        n_meta.off = i_cfg.gain_mode[1];
        n_meta.cap = have && i_cfg.peak_protect_enable;
    end

    // Exponent in units of 2^-32; the top bits are the floor, the rest the fraction.
    assign p      = {{(EXP_W-SUM_W){r1_s[SUM_W-1]}}, r1_s} * EXP_W'(LOG2_10_OVER_20_Q24);
    assign prod_y = (F_W+Y_W)'(r2_f) * (F_W+Y_W)'(LN2_Q30);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
            r2_valid <= 1'b0;
            r3_valid <= 1'b0;
        end else if (i_en) begin
            r1_valid <= i_valid;
            r2_valid <= r1_valid;
            r3_valid <= r2_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_s    <= n_s;
            r1_pk   <= n_pk;
            r1_meta <= n_meta;
            r2_n    <= p[EXP_W-1:F_W];
            r2_f    <= p[F_W-1:0];
            r2_meta <= r1_meta;
            r3_n    <= r2_n;
            r3_y    <= prod_y[F_W+Y_W-1:F_W];
            r3_meta <= r2_meta;
        end
    end

    assign o_pk    = r1_pk;
    assign o_valid = r3_valid;
    assign o_meta  = r3_meta;
    assign o_n     = r3_n;
    assign o_y     = r3_y;

endmodule

// File: rtl/rgm_exp2.sv
// Series evaluation of 2^f in Q.30: two stages per term (product, reciprocal divide).
// Depends on rgm_pkg.
module rgm_exp2 import rgm_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_valid,
    input  t_meta                 i_meta,
    input  logic signed [N_W-1:0] i_n,
    input  logic [Y_W-1:0]        i_y,
    output logic                  o_valid,
    output t_meta                 o_meta,
    output logic signed [N_W-1:0] o_n,
    output logic [R_W-1:0]        o_r,
    output logic [TERM_W-1:0]     o_q,
    output logic [TERM_W-1:0]     o_x
);

    logic                  r_av    [SERIES_K];
    logic [TERM_W-1:0]     r_ax    [SERIES_K];
    logic [R_W-1:0]        r_ar    [SERIES_K];
    logic [Y_W-1:0]        r_ay    [SERIES_K];
    logic signed [N_W-1:0] r_an    [SERIES_K];
    t_meta                 r_ameta [SERIES_K];
    logic                  r_bv    [SERIES_K];
    logic [TERM_W-1:0]     r_bq    [SERIES_K];
    logic [TERM_W-1:0]     r_bx    [SERIES_K];
    logic [R_W-1:0]        r_br    [SERIES_K];
    logic [Y_W-1:0]        r_by    [SERIES_K];
    logic signed [N_W-1:0] r_bn    [SERIES_K];
    t_meta                 r_bmeta [SERIES_K];

    for (genvar k = 1; k <= SERIES_K; k++) begin : g_term
        logic                     in_v;
        t_meta                    in_meta;
        logic signed [N_W-1:0]    in_n;
        logic [Y_W-1:0]           in_y;
        logic [TERM_W-1:0]        in_term;
        logic [R_W-1:0]           in_r;
        logic [TERM_W+Y_W-1:0]    prod_a;
        logic [TERM_W-1:0]        n_q;

        // The previous term is finished here: its divide is corrected and summed.
        if (k == 1) begin : g_first
            assign in_v    = i_valid;
            assign in_meta = i_meta;
            assign in_n    = i_n;
            assign in_y    = i_y;
            assign in_term = ONE_Q30;
            assign in_r    = '0;
        end else begin : g_next
            assign in_v    = r_bv[k-2];
            assign in_meta = r_bmeta[k-2];
            assign in_n    = r_bn[k-2];
            assign in_y    = r_by[k-2];
            assign in_term = div_fix(r_bq[k-2], r_bx[k-2], 4'(k-1));
            assign in_r    = r_br[k-2] + R_W'(in_term);
        end

        assign prod_a = (TERM_W+Y_W)'(in_term) * (TERM_W+Y_W)'(in_y);

        if (k == 1) begin : g_div1
            assign n_q = r_ax[k-1];
        end else begin : g_divk
            localparam logic [TERM_W-1:0] RECIP = TERM_W'((64'd1 << TERM_W) / k);
            logic [2*TERM_W-1:0] prod_b;
            assign prod_b = (2*TERM_W)'(r_ax[k-1]) * (2*TERM_W)'(RECIP);
            assign n_q    = prod_b[2*TERM_W-1:TERM_W];
        end

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_av[k-1] <= 1'b0;
                r_bv[k-1] <= 1'b0;
            end else if (i_en) begin
                r_av[k-1] <= in_v;
                r_bv[k-1] <= r_av[k-1];
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_ax[k-1]    <= prod_a[TERM_W+Y_W-1:Y_W];
                r_ar[k-1]    <= in_r + ((k == 1) ? R_W'(in_term) : '0);
                r_ay[k-1]    <= in_y;
                r_an[k-1]    <= in_n;
                r_ameta[k-1] <= in_meta;
                r_bq[k-1]    <= n_q;
                r_bx[k-1]    <= r_ax[k-1];
                r_br[k-1]    <= r_ar[k-1];
                r_by[k-1]    <= r_ay[k-1];
                r_bn[k-1]    <= r_an[k-1];
                r_bmeta[k-1] <= r_ameta[k-1];
            end
        end
    end

    assign o_valid = r_bv[SERIES_K-1];
    assign o_meta  = r_bmeta[SERIES_K-1];
    assign o_n     = r_bn[SERIES_K-1];
    assign o_r     = r_br[SERIES_K-1];
    assign o_q     = r_bq[SERIES_K-1];
    assign o_x     = r_bx[SERIES_K-1];

endmodule

// File: rtl/rgm_recip.sv
// Pipelined restoring divider for the peak cap, (2^32 + peak/2) / peak in Q16.16.
// Depends on rgm_pkg; runs in lockstep with the main pipeline.
module rgm_recip import rgm_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [PK_W-1:0]  i_pk,
    output logic [LIM_W-1:0] o_limit
);

    logic [PK_W-1:0]  r_rem [DIV_STAGES];
    logic [DIV_W-1:0] r_dd  [DIV_STAGES];
    logic [LIM_W-1:0] r_q   [DIV_STAGES];
    logic [PK_W-1:0]  r_d   [DIV_STAGES];

    for (genvar j = 0; j < DIV_STAGES; j++) begin : g_stage
        logic [PK_W-1:0]  in_rem, rem;
        logic [DIV_W-1:0] in_dd, dd;
        logic [LIM_W-1:0] in_q, q;
        logic [PK_W-1:0]  in_d;
        logic [PK_W:0]    sh;

        // The dividend sits at the bottom of a wider word; leading zero steps add nothing.
        if (j == 0) begin : g_load
            assign in_rem = '0;
            assign in_dd  = DIV_W'({1'b1, {(LIM_W-PK_W){1'b0}}, i_pk[PK_W-1:1]});
            assign in_q   = '0;
            assign in_d   = i_pk;
        end else begin : g_chain
            assign in_rem = r_rem[j-1];
            assign in_dd  = r_dd[j-1];
            assign in_q   = r_q[j-1];
            assign in_d   = r_d[j-1];
        end

        always_comb begin
            rem = in_rem;
            dd  = in_dd;
            q   = in_q;
            sh  = '0;
            for (int s = 0; s < DIV_SPS; s++) begin
                sh = {rem, dd[DIV_W-1]};
                dd = dd << 1;
                if (sh >= {1'b0, in_d}) begin
                    rem = PK_W'(sh - {1'b0, in_d});
                    q   = {q[LIM_W-2:0], 1'b1};
                end else begin
                    rem = sh[PK_W-1:0];
                    q   = {q[LIM_W-2:0], 1'b0};
                end
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[j] <= rem;
                r_dd[j]  <= dd;
                r_q[j]   <= q;
                r_d[j]   <= in_d;
            end
        end
    end

    assign o_limit = r_q[DIV_STAGES-1];

endmodule

// File: rtl/replay_gain_multiplier.sv
// Top level: configuration registers, pipeline control and the back stages
// (exponent shift, peak cap, output gain). Depends on rgm_pkg and the rgm_* modules.
//
//  channel   direction  handshake            payload
//  tags      in         i_valid / o_stall    i_track_* i_album_* i_ref_loudness_*
//  result    out        o_valid / i_stall    o_multiplier o_saturated
//  config    in         i_cfg_wr_en          i_cfg_index i_cfg_data
//
// One tag set is taken every cycle while o_stall is low.
// The depth is set by the twelve-term exponential series, two stages per term.
// All stages advance together; a stalled full output register holds the whole pipeline.
// Reset clears the valid bits and loads the register defaults (mode off, unity gain).
module replay_gain_multiplier import rgm_pkg::*; (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic                     i_track_gain_present,
    input  logic signed [GAIN_W-1:0] i_track_gain_db,
    input  logic                     i_album_gain_present,
    input  logic signed [GAIN_W-1:0] i_album_gain_db,
    input  logic                     i_track_peak_present,
    input  logic signed [PEAK_W-1:0] i_track_peak,
    input  logic                     i_album_peak_present,
    input  logic signed [PEAK_W-1:0] i_album_peak,
    input  logic                     i_ref_loudness_present,
    input  logic signed [GAIN_W-1:0] i_ref_loudness_lufs,
    input  logic                     i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [CFG_DATA_W-1:0]    i_cfg_data,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [MULT_W-1:0]        o_multiplier,
    output logic                     o_saturated
);

    t_cfg                  r_cfg;
    logic                  en;
    logic [PK_W-1:0]       pk;
    logic                  f_valid;
    t_meta                 f_meta;
    logic signed [N_W-1:0] f_n;
    logic [Y_W-1:0]        f_y;
    logic                  e_valid;
    t_meta                 e_meta;
    logic signed [N_W-1:0] e_n;
    logic [R_W-1:0]        e_r;
    logic [TERM_W-1:0]     e_q, e_x;
    logic [LIM_W-1:0]      limit;

    logic                  r28_valid, r29_valid, r30_valid, r31_valid, r_out_valid;
    t_meta                 r28_meta, r29_meta, r30_meta, r31_meta;
    logic signed [N_W-1:0] r28_n;
    logic [R_W-1:0]        r28_r;
    logic [M_W-1:0]        r29_m, r30_m;
    logic                  r29_sat, r30_sat, r31_sat;
    logic [M_W+OG_W-1:0]   r31_prod;
    logic [MULT_W-1:0]     r_mult;
    logic                  r_sat;

    logic signed [N_W:0]   sh;
    logic [4:0]            sh_amt;
    logic [M_W:0]          rounded;
    logic [M_W-1:0]        n_m;
    logic                  n_sat29;
    logic [M_W-1:0]        n_mc;
    logic [M_W+OG_W:0]     res_full;
    logic [MULT_W-1:0]     n_mult;
    logic                  n_sat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.gain_mode           <= MODE_OFF;
            r_cfg.preamp_db           <= '0;
            r_cfg.fallback_gain_db    <= -16'sd1792;
            r_cfg.peak_protect_enable <= 1'b1;
            r_cfg.output_gain         <= OG_W'(ONE_Q16);
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_GAIN_MODE:    r_cfg.gain_mode           <= i_cfg_data[1:0];
                CFG_PREAMP_DB:    r_cfg.preamp_db           <= i_cfg_data[GAIN_W-1:0];
                CFG_FALLBACK_DB:  r_cfg.fallback_gain_db    <= i_cfg_data[GAIN_W-1:0];
                CFG_PEAK_PROTECT: r_cfg.peak_protect_enable <= i_cfg_data[0];
                CFG_OUTPUT_GAIN:  r_cfg.output_gain         <= i_cfg_data[OG_W-1:0];
                default: ;
            endcase
        end
    end

    assign en      = !r_out_valid || !i_stall;
    assign o_stall = !en;

    rgm_front u_front (
        .i_clk                  (i_clk),
        .i_rst_n                (i_rst_n),
        .i_en                   (en),
        .i_valid                (i_valid),
        .i_cfg                  (r_cfg),
        .i_track_gain_present   (i_track_gain_present),
        .i_track_gain_db        (i_track_gain_db),
        .i_album_gain_present   (i_album_gain_present),
        .i_album_gain_db        (i_album_gain_db),
        .i_track_peak_present   (i_track_peak_present),
        .i_track_peak           (i_track_peak),
        .i_album_peak_present   (i_album_peak_present),
        .i_album_peak           (i_album_peak),
        .i_ref_loudness_present (i_ref_loudness_present),
        .i_ref_loudness_lufs    (i_ref_loudness_lufs),
        .o_pk                   (pk),
        .o_valid                (f_valid),
        .o_meta                 (f_meta),
        .o_n                    (f_n),
        .o_y                    (f_y)
    );

    rgm_recip u_recip (
        .i_clk   (i_clk),
        .i_en    (en),
        .i_pk    (pk),
        .o_limit (limit)
    );

    rgm_exp2 u_exp2 (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_valid (f_valid),
        .i_meta  (f_meta),
        .i_n     (f_n),
        .i_y     (f_y),
        .o_valid (e_valid),
        .o_meta  (e_meta),
        .o_n     (e_n),
        .o_r     (e_r),
        .o_q     (e_q),
        .o_x     (e_x)
    );

    // Scale 2^f by 2^n into Q16.16, rounding half up on right shifts.
    always_comb begin
        sh      = (N_W+1)'(14) - {r28_n[N_W-1], r28_n};
        sh_amt  = sh[4:0];
        rounded = '0;
        n_sat29 = 1'b0;
        if (r28_n >= N_W'(16)) begin
            n_m     = '1;
            n_sat29 = 1'b1;
        end else if (r28_n < -N_W'(17)) begin
            n_m = '0;
        end else if (sh > 0) begin
            rounded = {1'b0, r28_r} + ((M_W+1)'(1) << (sh_amt - 5'd1));
            n_m     = M_W'(rounded >> sh_amt);
        end else if (sh == '0) begin
            n_m = r28_r;
        end else begin
            n_m = r28_r << 1;
        end
    end

    // The divider output lines up with the item held in the r29 stage.
    assign n_mc = (r29_meta.cap && ({1'b0, r29_m} > limit)) ? limit[M_W-1:0] : r29_m;

    always_comb begin
        res_full = {1'b0, r31_prod} + (M_W+OG_W+1)'(32768);
        if (r31_meta.off) begin
            n_mult = MULT_W'(r_cfg.output_gain);
            n_sat  = 1'b0;
        end else if (res_full[M_W+OG_W:16] > (M_W+OG_W-15)'(MULT_MAX)) begin
            n_mult = MULT_MAX;
            n_sat  = 1'b1;
        end else begin
            n_mult = res_full[MULT_W+15:16];
            n_sat  = r31_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r28_valid   <= 1'b0;
            r29_valid   <= 1'b0;
            r30_valid   <= 1'b0;
            r31_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r28_valid   <= e_valid;
            r29_valid   <= r28_valid;
            r30_valid   <= r29_valid;
            r31_valid   <= r30_valid;
            r_out_valid <= r31_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r28_meta <= e_meta;
            r28_n    <= e_n;
            r28_r    <= e_r + R_W'(div_fix(e_q, e_x, 4'(SERIES_K)));
            r29_meta <= r28_meta;
            r29_m    <= n_m;
            r29_sat  <= n_sat29;
            r30_meta <= r29_meta;
            r30_m    <= n_mc;
            r30_sat  <= r29_sat;
            r31_meta <= r30_meta;
            r31_prod <= (M_W+OG_W)'(r30_m) * (M_W+OG_W)'(r_cfg.output_gain);
            r31_sat  <= r30_sat;
            r_mult   <= n_mult;
            r_sat    <= n_sat;
        end
    end

    assign o_valid      = r_out_valid;
    assign o_multiplier = r_mult;
    assign o_saturated  = r_sat;

endmodule

// File: rtl/rgm_checker.sv
// Port-level checks of the replay gain multiplier, bound to the top level.
// Depends on rgm_pkg and replay_gain_multiplier.
module rgm_checker import rgm_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [MULT_W-1:0] o_multiplier,
    input logic              o_saturated
);

    // A held result keeps its value until the transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_multiplier) && $stable(o_saturated))
        else $error("result changed while stalled");

    // The input side stalls only when a finished result waits downstream.
    a_stall_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall == (o_valid && i_stall))
        else $error("input stall does not follow the output register");

    // A stalled tag set is not withdrawn before its transfer.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_stall |=> i_valid)
        else $error("input valid dropped while stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid right after reset");

endmodule

bind replay_gain_multiplier rgm_checker u_rgm_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_valid      (i_valid),
    .o_stall      (o_stall),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_multiplier (o_multiplier),
    .o_saturated  (o_saturated)
);
